>>> rtl/skrc_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and constants of the skin tone pixel recolor block
// no dependencies
package skrc_pkg;

  // field and register widths
  localparam int NUM_KEYS   = 4;
  localparam int NUM_CH     = 3;
  localparam int CH_W       = 8;
  localparam int RGB_W      = 24;
  localparam int PIX_W      = 32;
  localparam int TOL_W      = 8;
  localparam int RAD_W      = 18;
  localparam int SQ_W       = 16;
  localparam int SQ_SUM_W   = 18;
  localparam int LUM_W      = 22;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_KEY_A  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_B  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_C  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_D  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TOL    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS = 3'd6;

  // register reset values
  localparam logic [RGB_W-1:0] KEY_A_RST  = 24'hDBC797;
  localparam logic [RGB_W-1:0] KEY_B_RST  = 24'hBFA373;
  localparam logic [RGB_W-1:0] KEY_C_RST  = 24'hA78353;
  localparam logic [RGB_W-1:0] KEY_D_RST  = 24'hA49571;
  localparam logic [RGB_W-1:0] TARGET_RST = 24'h5B2F13;
  localparam logic [TOL_W-1:0] TOL_RST    = 8'd16;
  localparam logic [RAD_W-1:0] RADIUS_RST = 18'd576;

  // luminance weights in units of 1/10000
  localparam logic [LUM_W-1:0] COEF_R = LUM_W'(2126);
  localparam logic [LUM_W-1:0] COEF_G = LUM_W'(7152);
  localparam logic [LUM_W-1:0] COEF_B = LUM_W'(722);

  // scaling: q = floor((2*t*L + LREF) / (2*LREF))
  localparam int          PROD_W       = CH_W + LUM_W;
  localparam int          NUM_W        = PROD_W + 1;
  localparam int          RECIP_W      = 19;
  localparam int          RECIP_SHIFT  = 40;
  localparam int          PRODQ_W      = NUM_W + RECIP_W;
  localparam int          QUOT_W       = 9;
  localparam int          CMP_W        = 32;
  localparam int unsigned LREF_VAL     = 1654872;
  localparam logic [NUM_W-1:0] LREF    = NUM_W'(LREF_VAL);
  localparam logic [CMP_W-1:0] DIVISOR = CMP_W'(2 * LREF_VAL);
  localparam logic [63:0] RECIP_FULL   = (64'd1 << RECIP_SHIFT) / (64'd2 * 64'(LREF_VAL));
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // configuration seen by the datapath
  typedef struct packed {
    logic [NUM_KEYS-1:0][RGB_W-1:0] key;
    logic [RGB_W-1:0]               target;
    logic [TOL_W-1:0]               tol;
    logic [RAD_W-1:0]               radius;
  } cfg_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             recolor;
    logic [LUM_W-1:0] lum;
  } item_t;

  // square of one channel difference
  function automatic logic [SQ_W-1:0] square8(input logic [CH_W-1:0] v);
    return SQ_W'(v) * SQ_W'(v);
  endfunction

endpackage

>>> rtl/skrc_if.sv
`timescale 1ns / 1ps
// valid/ready stream interfaces for the pixel input and the result output
// depends on skrc_pkg
interface pixel_in_if;
  import skrc_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_argb;
  logic             is_player_color;

  modport source (output valid, output pixel_argb, output is_player_color, input ready);
  modport sink   (input valid, input pixel_argb, input is_player_color, output ready);
endinterface

interface pixel_out_if;
  import skrc_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             was_recolored;

  modport source (output valid, output pixel_out, output was_recolored, input ready);
  modport sink   (input valid, input pixel_out, input was_recolored, output ready);
endinterface

>>> rtl/skrc_front.sv
`timescale 1ns / 1ps
// front: accepts pixels, matches them against the key colors, computes luminance
// depends on skrc_pkg and pixel_in_if
module skrc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  skrc_pkg::cfg_t       cfg,
  pixel_in_if.sink             pix_in,
  output logic                 push_valid,
  output skrc_pkg::item_t      push_data,
  input  logic                 push_ready
);
  import skrc_pkg::*;

  logic                                   en1;
  logic                                   en2;
  logic [NUM_KEYS-1:0][NUM_CH-1:0][CH_W-1:0] adiff_d;
  logic [NUM_KEYS-1:0]                    tol_ok_d;
  logic [LUM_W-1:0]                       lum_d;
  logic                                   pass_d;

  logic                                   s1_valid;
  logic [PIX_W-1:0]                       s1_pixel;
  logic                                   s1_pass;
  logic [NUM_KEYS-1:0][NUM_CH-1:0][CH_W-1:0] s1_adiff;
  logic [NUM_KEYS-1:0]                    s1_tol_ok;
  logic [LUM_W-1:0]                       s1_lum;

  logic [NUM_KEYS-1:0][SQ_SUM_W-1:0]      sqsum_d;
  logic [NUM_KEYS-1:0]                    hit_d;

  logic                                   s2_valid;
  item_t                                  s2_item;

  // stall control: each stage moves when the one after it can take
  assign en2          = !s2_valid || push_ready;
  assign en1          = !s1_valid || en2;
  assign pix_in.ready = en1;

  // stage 1 logic: per-channel absolute differences, tolerance test, luminance
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        adiff_d[k][c] = (pix_in.pixel_argb[c*CH_W +: CH_W] >= cfg.key[k][c*CH_W +: CH_W])
                      ? pix_in.pixel_argb[c*CH_W +: CH_W] - cfg.key[k][c*CH_W +: CH_W]
                      : cfg.key[k][c*CH_W +: CH_W] - pix_in.pixel_argb[c*CH_W +: CH_W];
      end
      tol_ok_d[k] = (adiff_d[k][0] <= cfg.tol) && (adiff_d[k][1] <= cfg.tol)
                 && (adiff_d[k][2] <= cfg.tol);
    end
    lum_d  = COEF_R * LUM_W'(pix_in.pixel_argb[2*CH_W +: CH_W])
           + COEF_G * LUM_W'(pix_in.pixel_argb[CH_W +: CH_W])
           + COEF_B * LUM_W'(pix_in.pixel_argb[0 +: CH_W]);
    pass_d = pix_in.is_player_color || (pix_in.pixel_argb[RGB_W +: CH_W] == '0);
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_pixel  <= pix_in.pixel_argb;
      s1_pass   <= pass_d;
      s1_adiff  <= adiff_d;
      s1_tol_ok <= tol_ok_d;
      s1_lum    <= lum_d;
    end
  end

  // stage 2 logic: squared distance per key and radius test
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      sqsum_d[k] = SQ_SUM_W'(square8(s1_adiff[k][0])) + SQ_SUM_W'(square8(s1_adiff[k][1]))
                 + SQ_SUM_W'(square8(s1_adiff[k][2]));
      hit_d[k]   = s1_tol_ok[k] && (sqsum_d[k] <= cfg.radius);
    end
  end

  // stage 2 registers, classified item
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_item.pixel   <= s1_pixel;
      s2_item.recolor <= !s1_pass && (|hit_d);
      s2_item.lum     <= s1_lum;
    end
  end

  assign push_valid = s2_valid;
  assign push_data  = s2_item;

endmodule

>>> rtl/skrc_queue.sv
`timescale 1ns / 1ps
// short fifo between the front and the back, lets each side stall on its own
// depends on skrc_pkg
module skrc_queue #(
  parameter int DEPTH = skrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  skrc_pkg::item_t push_data,
  output logic            push_ready,
  output logic            pop_valid,
  output skrc_pkg::item_t pop_data,
  input  logic            pop_ready
);
  import skrc_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  item_t             mem [DEPTH];
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/skrc_back.sv
`timescale 1ns / 1ps
// back: scales the target color by the pixel luminance and drives the result
// depends on skrc_pkg and pixel_out_if
module skrc_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [skrc_pkg::RGB_W-1:0] target,
  input  logic                      pop_valid,
  input  skrc_pkg::item_t           pop_data,
  output logic                      pop_ready,
  pixel_out_if.source               pix_out
);
  import skrc_pkg::*;

  logic                              en;

  logic [NUM_CH-1:0][PROD_W-1:0]     prod_d;
  logic                              a_valid;
  logic [PIX_W-1:0]                  a_pixel;
  logic                              a_rec;
  logic [NUM_CH-1:0][PROD_W-1:0]     a_prod;

  logic [NUM_CH-1:0][NUM_W-1:0]      num_d;
  logic [NUM_CH-1:0][PRODQ_W-1:0]    prodq_d;
  logic                              b_valid;
  logic [PIX_W-1:0]                  b_pixel;
  logic                              b_rec;
  logic [NUM_CH-1:0][NUM_W-1:0]      b_num;
  logic [NUM_CH-1:0][QUOT_W-1:0]     b_est;

  logic [NUM_CH-1:0][CMP_W-1:0]      chk_d;
  logic [NUM_CH-1:0][QUOT_W-1:0]     quot_d;
  logic [NUM_CH-1:0][CH_W-1:0]       chan_d;

  // whole back pipeline advances while the output register can take
  assign en        = !pix_out.valid || pix_out.ready;
  assign pop_ready = en;

  // stage a: target channel times luminance
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod_d[c] = PROD_W'(target[c*CH_W +: CH_W]) * PROD_W'(pop_data.lum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pixel <= pop_data.pixel;
      a_rec   <= pop_data.recolor;
      a_prod  <= prod_d;
    end
  end

  // stage b: rounding offset, then quotient estimate by reciprocal multiply
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      num_d[c]   = {a_prod[c], 1'b0} + LREF;
      prodq_d[c] = PRODQ_W'(num_d[c]) * PRODQ_W'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_pixel <= a_pixel;
      b_rec   <= a_rec;
      b_num   <= num_d;
      for (int c = 0; c < NUM_CH; c++) begin
        b_est[c] <= prodq_d[c][RECIP_SHIFT +: QUOT_W];
      end
    end
  end

  // estimate is low by at most one: correct it, then saturate
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      chk_d[c]  = CMP_W'(b_est[c]) * DIVISOR + DIVISOR;
      quot_d[c] = b_est[c] + QUOT_W'(CMP_W'(b_num[c]) >= chk_d[c]);
      chan_d[c] = (quot_d[c] > QUOT_W'(255)) ? 8'hFF : quot_d[c][CH_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (en) begin
      pix_out.valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_out.pixel_out     <= b_rec ? {b_pixel[RGB_W +: CH_W], chan_d[2], chan_d[1], chan_d[0]}
                                     : b_pixel;
      pix_out.was_recolored <= b_rec;
    end
  end

endmodule

>>> rtl/skin_tone_pixel_recolor.sv
`timescale 1ns / 1ps
// top level of the skin tone pixel recolor block: configuration registers,
// front, queue and back; depends on skrc_pkg, the stream interfaces and submodules
//
// Takes one ARGB pixel per clock and returns one ARGB pixel per clock, in order,
// while the output is not stalled. Pixels flagged as player color, pixels with
// alpha 0 and pixels that match none of the four key colors come out unchanged;
// a matching pixel gets the target color scaled by its luminance, with alpha
// kept. The front (two pipeline stages: channel differences and luminance, then
// squared distance) and the back (three stages: product, reciprocal multiply,
// correction and output register) each move one pixel per cycle unless stalled,
// so the sustained rate is one pixel per clock. A QUEUE_DEPTH-entry fifo sits
// between front and back, so the input keeps taking pixels while a result
// waits. Register writes take effect at the next clock edge.
module skin_tone_pixel_recolor #(
  parameter int QUEUE_DEPTH = skrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_en,
  input  logic [skrc_pkg::REG_IDX_W-1:0]  reg_index,
  input  logic [skrc_pkg::CFG_DATA_W-1:0] write_data,
  pixel_in_if.sink                       pix_in,
  pixel_out_if.source                    pix_out
);
  import skrc_pkg::*;

  cfg_t  cfg;
  logic  push_valid;
  item_t push_data;
  logic  push_ready;
  logic  pop_valid;
  item_t pop_data;
  logic  pop_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key[0]  <= KEY_A_RST;
      cfg.key[1]  <= KEY_B_RST;
      cfg.key[2]  <= KEY_C_RST;
      cfg.key[3]  <= KEY_D_RST;
      cfg.target  <= TARGET_RST;
      cfg.tol     <= TOL_RST;
      cfg.radius  <= RADIUS_RST;
    end else if (write_en) begin
      case (reg_index)
        REG_KEY_A:  cfg.key[0] <= write_data[RGB_W-1:0];
        REG_KEY_B:  cfg.key[1] <= write_data[RGB_W-1:0];
        REG_KEY_C:  cfg.key[2] <= write_data[RGB_W-1:0];
        REG_KEY_D:  cfg.key[3] <= write_data[RGB_W-1:0];
        REG_TARGET: cfg.target <= write_data[RGB_W-1:0];
        REG_TOL:    cfg.tol    <= write_data[TOL_W-1:0];
        REG_RADIUS: cfg.radius <= write_data[RAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: match and classify
  skrc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pix_in     (pix_in),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // queue between front and back
  skrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  // back: scale and deliver
  skrc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .target    (cfg.target),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .pix_out   (pix_out)
  );

endmodule

>>> rtl/skrc_checker.sv
`timescale 1ns / 1ps
// port-level checks of the skin tone pixel recolor block, bound to the top level
// depends on skrc_pkg and skin_tone_pixel_recolor
module skrc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [skrc_pkg::PIX_W-1:0] pixel_out,
  input logic                       was_recolored
);
  import skrc_pkg::*;

  logic [7:0] inflight;

  // pixels taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      case ({in_valid && in_ready, out_valid && out_ready})
        2'b10:   inflight <= inflight + 1'b1;
        2'b01:   inflight <= inflight - 1'b1;
        default: inflight <= inflight;
      endcase
    end
  end

  // a stalled result keeps its valid
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // a stalled result keeps its payload
  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pixel_out) && $stable(was_recolored))
    else $error("result payload changed while stalled");

  // no result without a pixel taken before it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("result shown with no pixel in flight");

  // transparent pixels are never recolored
  a_alpha_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_recolored |-> pixel_out[PIX_W-1 -: CH_W] != '0)
    else $error("recolored pixel has alpha 0");

endmodule

bind skin_tone_pixel_recolor skrc_checker u_skrc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pix_in.valid),
  .in_ready      (pix_in.ready),
  .out_valid     (pix_out.valid),
  .out_ready     (pix_out.ready),
  .pixel_out     (pix_out.pixel_out),
  .was_recolored (pix_out.was_recolored)
);
